/* hw/rtl/sma_pkg.sv */
// shared types and constants of the stack machine arithmetic unit
// used by sma_cell, sma_div and stack_machine_arith_unit_top; no dependencies
`timescale 1ns / 1ps

package sma_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned DepthFieldW  = 7;
  localparam int unsigned CmdW         = 3;
  localparam int unsigned StatusW      = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_NOP  = 3'd0,
    CMD_PUSH = 3'd1,
    CMD_SWAP = 3'd2,
    CMD_ADD  = 3'd3,
    CMD_SUB  = 3'd4,
    CMD_DIV  = 3'd5,
    CMD_MUL  = 3'd6
  } sma_cmd_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_DIV0  = 2'd2,
    STATUS_FULL  = 2'd3
  } sma_status_e;

  // what a stack cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_DOWN = 2'd1,  // take the entry from the neighbor nearer the top
    CELL_UP   = 2'd2,  // take the entry from the neighbor farther from the top
    CELL_LOAD = 2'd3   // take the load word
  } sma_cell_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } sma_state_e;

endpackage

/* hw/rtl/sma_cell.sv */
// one entry of the shifting stack chain
// depends on sma_pkg
`timescale 1ns / 1ps

module sma_cell import sma_pkg::*; (
  input  logic               clk_i,
  input  sma_cell_op_e       op_i,
  input  logic [WordW-1:0]   prev_i,
  input  logic [WordW-1:0]   next_i,
  input  logic [WordW-1:0]   load_i,
  output logic [WordW-1:0]   val_o
);

  logic [WordW-1:0] val_d, val_q;

  always_comb begin
    case (op_i)
      CELL_HOLD: val_d = val_q;
      CELL_DOWN: val_d = prev_i;
      CELL_UP:   val_d = next_i;
      CELL_LOAD: val_d = load_i;
      default:   val_d = val_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

/* hw/rtl/sma_div.sv */
// iterative radix-2 signed divider, truncating toward zero
// depends on sma_pkg
`timescale 1ns / 1ps

module sma_div import sma_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] num_i,
  input  logic [WordW-1:0] den_i,
  output logic             done_o,
  output logic [WordW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(WordW + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(WordW);

  logic            busy_d, busy_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic [WordW-1:0] rem_d, rem_q;
  logic [WordW-1:0] q_d, q_q;
  logic [WordW-1:0] dm_d, dm_q;
  logic             neg_d, neg_q;
  logic [WordW:0]   shifted;
  logic [WordW+1:0] diff;

  assign shifted = {rem_q, q_q[WordW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dm_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    q_d    = q_q;
    dm_d   = dm_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      q_d    = num_i[WordW-1] ? (~num_i + 1'b1) : num_i;
      dm_d   = den_i[WordW-1] ? (~den_i + 1'b1) : den_i;
      neg_d  = num_i[WordW-1] ^ den_i[WordW-1];
    end else if (busy_q) begin
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (!diff[WordW+1]) begin
          rem_d = diff[WordW-1:0];
          q_d   = {q_q[WordW-2:0], 1'b1};
        end else begin
          rem_d = shifted[WordW-1:0];
          q_d   = {q_q[WordW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    dm_q  <= dm_d;
    neg_q <= neg_d;
  end

  assign done_o = busy_q && (cnt_q == LastCnt);
  assign quot_o = neg_q ? (~q_q + 1'b1) : q_q;

endmodule

/* hw/rtl/stack_machine_arith_unit_top.sv */
// top level of the stack machine arithmetic unit: handshake, control, stack chain
// depends on sma_pkg, sma_cell and sma_div
`timescale 1ns / 1ps

// A bounded stack of signed 32-bit words held in a row of STACK_DEPTH cells,
// the top entry in cell 0. Each input beat carries one command (nop, push,
// swap, add, sub, div, mul) and gives exactly one output beat with the status,
// the new top entry (0 when empty) and the new depth. Arithmetic commands pop
// the top T and replace the entry below, S, with S op T; add, sub and mul
// wrap to 32 bits, div truncates toward zero. Push and pop move every cell by
// one place away from or toward the top together; swap exchanges the top
// two cells. Nop, push, swap, add, sub, mul and any error load the output
// register in the cycle they are accepted; a div goes through accept, 32
// radix-2 steps of the divider and a result step, so a div sets the
// worst-case rate. A new input beat is taken only when the output register
// is empty or the receiver takes the waiting result in the same cycle, and
// never while a divide is running; a held-back result stalls the input.
module stack_machine_arith_unit_top import sma_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beat: [2:0] cmd, [34:3] push_value, [39:35] zero
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,
  // output beat: [1:0] status, [33:2] top_value, [40:34] stack_depth, [47:41] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] TwoCnt  = CntW'(2);

  // state
  sma_state_e state_d, state_q;
  logic [CntW-1:0] cnt_d, cnt_q;

  // output register
  logic               out_valid_d, out_valid_q;
  logic [StatusW-1:0] out_status_d, out_status_q;
  logic [WordW-1:0]   out_top_d, out_top_q;
  logic [DepthFieldW-1:0] out_depth_d, out_depth_q;

  // stack chain
  logic [WordW-1:0] cell_val [STACK_DEPTH];
  sma_cell_op_e     cell_op  [STACK_DEPTH];
  logic [WordW-1:0] load_word;

  // decode
  logic       accept;
  sma_cmd_e   cmd;
  logic [WordW-1:0] push_value;
  logic [WordW-1:0] top_w, sec_w;
  logic       short_stack, full_stack;
  logic       div_start, div_done;
  logic [WordW-1:0] div_quot;
  logic [WordW-1:0] alu_r;
  logic [WordW-1:0] top_next;
  logic       out_load;
  logic [CntW+DepthFieldW-1:0] depth_ext;

  assign cmd        = sma_cmd_e'(s_axis_tdata_i[CmdW-1:0]);
  assign push_value = s_axis_tdata_i[CmdW+WordW-1:CmdW];
  assign top_w      = cell_val[0];
  assign sec_w      = cell_val[1];
  assign short_stack = cnt_q < TwoCnt;
  assign full_stack  = cnt_q == FullCnt;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // combinational ops, S op T
  always_comb begin
    case (cmd)
      CMD_ADD: alu_r = sec_w + top_w;
      CMD_SUB: alu_r = sec_w - top_w;
      CMD_MUL: alu_r = sec_w * top_w;
      default: alu_r = sec_w;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (div_start) state_d = ST_DIV;
      ST_DIV:  if (div_done)  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
    end
    load_word    = alu_r;
    cnt_d        = cnt_q;
    out_status_d = STATUS_OK;
    top_next     = top_w;
    div_start    = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (cmd)
            CMD_PUSH: begin
              if (full_stack) begin
                out_status_d = STATUS_FULL;
              end else begin
                for (int i = 0; i < STACK_DEPTH; i++) begin
                  cell_op[i] = CELL_DOWN;
                end
                cnt_d    = cnt_q + 1'b1;
                top_next = push_value;
              end
            end
            CMD_SWAP: begin
              if (short_stack) begin
                out_status_d = STATUS_SHORT;
              end else begin
                cell_op[0] = CELL_UP;
                cell_op[1] = CELL_DOWN;
                top_next   = sec_w;
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL: begin
              if (short_stack) begin
                out_status_d = STATUS_SHORT;
              end else begin
                cell_op[0] = CELL_LOAD;
                for (int i = 1; i < STACK_DEPTH; i++) begin
                  cell_op[i] = CELL_UP;
                end
                cnt_d    = cnt_q - 1'b1;
                top_next = alu_r;
              end
            end
            CMD_DIV: begin
              if (short_stack) begin
                out_status_d = STATUS_SHORT;
              end else if (top_w == '0) begin
                out_status_d = STATUS_DIV0;
              end else begin
                // result comes back from the divider
                div_start = 1'b1;
                out_load  = 1'b0;
              end
            end
            default: ;  // nop and the unused code
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          out_load   = 1'b1;
          load_word  = div_quot;
          cell_op[0] = CELL_LOAD;
          for (int i = 1; i < STACK_DEPTH; i++) begin
            cell_op[i] = CELL_UP;
          end
          cnt_d    = cnt_q - 1'b1;
          top_next = div_quot;
        end
      end
      default: ;
    endcase
  end

  // output register
  assign depth_ext = (CntW + DepthFieldW)'(cnt_d);

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (out_load)        out_valid_d = 1'b1;
    out_top_d   = (cnt_d != '0) ? top_next : '0;
    out_depth_d = depth_ext[DepthFieldW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_top_q    <= out_top_d;
      out_depth_q  <= out_depth_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_depth_q, out_top_q, out_status_q};

  // stack chain: cell 0 is the top, push shifts away from it, pop toward it
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [WordW-1:0] prev_w, next_w, load_w;
    if (g == 0) begin : g_top
      assign prev_w = push_value;
      assign load_w = load_word;
    end else begin : g_mid
      assign prev_w = cell_val[g-1];
      assign load_w = '0;
    end
    if (g == STACK_DEPTH - 1) begin : g_last
      assign next_w = cell_val[g];
    end else begin : g_inner
      assign next_w = cell_val[g+1];
    end
    sma_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op[g]),
      .prev_i (prev_w),
      .next_i (next_w),
      .load_i (load_w),
      .val_o  (cell_val[g])
    );
  end

  // divider, S / T
  sma_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sec_w),
    .den_i   (top_w),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("stack count above depth");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside a divide");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == CMD_PUSH && !full_stack |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push did not grow the stack");

  a_no_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> !s_axis_tready_o && !out_valid_q)
    else $error("beat taken or result pending while dividing");

endmodule
